@@ src/idsu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types for the signed/unsigned integer divider.
// No dependencies; used by idsu_cell and integer_divider_signed_unsigned_core.
package idsu_pkg;

    typedef struct packed {
        logic load;
        logic shift;
        logic take;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIX  = 3'b100
    } state_t;

endpackage

@@ src/idsu_cell.sv @@
`timescale 1ns / 1ps
// One bit slice of the divider: remainder, quotient/dividend and divisor bit,
// plus its stage of the borrow chain. Depends on idsu_pkg.
module idsu_cell
(
    input  logic                clk,
    input  idsu_pkg::cell_ctrl_t ctrl,
    input  logic                load_quo,
    input  logic                load_div,
    input  logic                rem_in,
    input  logic                quo_in,
    input  logic                borrow_in,
    output logic                borrow_out,
    output logic                rem_bit,
    output logic                quo_bit
);

    logic rem_reg;
    logic rem_next;
    logic quo_reg;
    logic quo_next;
    logic div_reg;
    logic div_next;
    logic diff;

    // shifted remainder bit minus divisor bit
    assign diff       = rem_in ^ div_reg ^ borrow_in;
    assign borrow_out = (~rem_in & div_reg) | (~(rem_in ^ div_reg) & borrow_in);

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        if (ctrl.load)
        begin
            rem_next = 1'b0;
            quo_next = load_quo;
            div_next = load_div;
        end
        else if (ctrl.shift)
        begin
            rem_next = ctrl.take ? diff : rem_in;
            quo_next = quo_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rem_bit = rem_reg;
    assign quo_bit = quo_reg;

endmodule

@@ src/integer_divider_signed_unsigned_core.sv @@
`timescale 1ns / 1ps
// Signed/unsigned restoring integer divider, top level.
// Depends on idsu_pkg and idsu_cell.
//
// A word is taken when start is high and busy is low. Its quotient and
// remainder appear on the result ports with done high for exactly one cycle.
// The operand magnitudes load into the row of bit cells at the accepting
// edge. In the divide state the cells then develop one quotient bit each
// step, and a sign fix-up state registers the result, which done follows
// from a register. The results cannot be held off: done is a single-cycle
// strobe that the receiver must capture. A new word may be started in the
// cycle that done is high; busy stays high until then, so only one word is
// in flight at a time.
// Division by zero gives quotient 0 and remainder equal to the dividend.
module integer_divider_signed_unsigned_core
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             mode,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH);

    idsu_pkg::state_t     state_reg;
    idsu_pkg::state_t     state_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 neg_q_reg;
    logic                 neg_r_reg;
    logic                 zero_reg;
    logic                 done_reg;
    logic [WIDTH-1:0]     quotient_reg;
    logic [WIDTH-1:0]     remainder_reg;

    idsu_pkg::cell_ctrl_t ctrl;
    logic                 accept;
    logic [WIDTH-1:0]     mag_n;
    logic [WIDTH-1:0]     mag_d;
    logic [WIDTH-1:0]     rem_bits;
    logic [WIDTH-1:0]     quo_bits;
    logic [WIDTH:0]       borrow;
    logic [WIDTH-1:0]     rem_in;
    logic [WIDTH-1:0]     quo_in;

    assign accept = start & ~busy;
    assign busy   = (state_reg != idsu_pkg::ST_IDLE);

    assign mag_n = (mode & dividend[WIDTH-1]) ? (~dividend + 1'b1) : dividend;
    assign mag_d = (mode & divisor[WIDTH-1])  ? (~divisor + 1'b1)  : divisor;

    // take when shifted-out bit is set or no borrow out of the chain
    assign ctrl.load  = accept;
    assign ctrl.shift = (state_reg == idsu_pkg::ST_DIV);
    assign ctrl.take  = rem_bits[WIDTH-1] | ~borrow[WIDTH];

    assign borrow[0] = 1'b0;
    assign rem_in    = {rem_bits[WIDTH-2:0], quo_bits[WIDTH-1]};
    assign quo_in    = {quo_bits[WIDTH-2:0], ctrl.take};

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        idsu_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_quo   (mag_n[i]),
            .load_div   (mag_d[i]),
            .rem_in     (rem_in[i]),
            .quo_in     (quo_in[i]),
            .borrow_in  (borrow[i]),
            .borrow_out (borrow[i+1]),
            .rem_bit    (rem_bits[i]),
            .quo_bit    (quo_bits[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            idsu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = idsu_pkg::ST_DIV;
                    cnt_next   = CW'(WIDTH - 1);
                end
            end
            idsu_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = idsu_pkg::ST_FIX;
                end
            end
            idsu_pkg::ST_FIX:
            begin
                state_next = idsu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = idsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idsu_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == idsu_pkg::ST_FIX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_q_reg <= mode & (dividend[WIDTH-1] ^ divisor[WIDTH-1]);
            neg_r_reg <= mode & dividend[WIDTH-1];
            zero_reg  <= (divisor == '0);
        end
        if (state_reg == idsu_pkg::ST_FIX)
        begin
            // with a zero divisor the remainder cells end up holding |dividend|
            quotient_reg  <= zero_reg ? '0 : (neg_q_reg ? (~quo_bits + 1'b1) : quo_bits);
            remainder_reg <= neg_r_reg ? (~rem_bits + 1'b1) : rem_bits;
        end
    end

    assign done      = done_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule
